// File: src/ksd_pkg.sv
// ----------------------------------------------------------------------------
// ksd_pkg
// Shared types, constants and scan code tables for the scan code decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ksd_pkg;

	// Command queue geometry
	localparam int CMD_QUEUE_DEPTH = 32;
	localparam int QIDX_W = $clog2(CMD_QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

	// Keyboard protocol bytes
	localparam logic [7:0] LED_CMD    = 8'hED;
	localparam logic [7:0] KB_ACK     = 8'hFA;
	localparam logic [7:0] KB_RESEND  = 8'hFE;

	// Scan codes with a special meaning
	localparam logic [7:0] SC_TAB      = 8'h0F;
	localparam logic [7:0] SC_F11      = 8'h57;
	localparam logic [7:0] SC_F1       = 8'h3B;
	localparam logic [7:0] SC_F2       = 8'h3C;
	localparam logic [7:0] SC_LSH_MAKE = 8'h2A;
	localparam logic [7:0] SC_RSH_MAKE = 8'h36;
	localparam logic [7:0] SC_LSH_BRK  = 8'hAA;
	localparam logic [7:0] SC_RSH_BRK  = 8'hB6;
	localparam logic [7:0] SC_CAPS     = 8'h3A;
	localparam logic [7:0] SC_NUM      = 8'h45;
	localparam logic [7:0] SC_SCROLL   = 8'h46;

	// Request kinds on the input channel
	localparam logic ACT_BYTE  = 1'b0;
	localparam logic ACT_START = 1'b1;

	// Reported key events
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_TAB     = 3'd1,
		EV_F11     = 3'd2,
		EV_SH_F1   = 3'd3,
		EV_SH_F2   = 3'd4
	} key_event_t;

	// LED bit positions
	localparam int LED_CAPS   = 2;
	localparam int LED_NUM    = 1;
	localparam int LED_SCROLL = 0;

	// Queue control from the decoder to the queue
	typedef struct packed {
		logic push;   // queue LED command and LED bits
		logic pop;    // take head byte
	} ksd_qctl_t;

	// Plain (unshifted) map, codes 0x00..0x7F
	function automatic logic [6:0] plain_map(input logic [6:0] code);
		logic [6:0] c;
		c = 7'h00;
		case (code)
			7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33; 7'h05: c = 7'h34;
			7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37; 7'h09: c = 7'h38;
			7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h2D; 7'h0D: c = 7'h5E;
			7'h0E: c = 7'h08;
			7'h10: c = 7'h51; 7'h11: c = 7'h57; 7'h12: c = 7'h45; 7'h13: c = 7'h52;
			7'h14: c = 7'h54; 7'h15: c = 7'h59; 7'h16: c = 7'h55; 7'h17: c = 7'h49;
			7'h18: c = 7'h4F; 7'h19: c = 7'h50; 7'h1A: c = 7'h40; 7'h1B: c = 7'h5B;
			7'h1C: c = 7'h0A; 7'h1E: c = 7'h41; 7'h1F: c = 7'h53;
			7'h20: c = 7'h44; 7'h21: c = 7'h46; 7'h22: c = 7'h47; 7'h23: c = 7'h48;
			7'h24: c = 7'h4A; 7'h25: c = 7'h4B; 7'h26: c = 7'h4C; 7'h27: c = 7'h3B;
			7'h28: c = 7'h3A; 7'h2B: c = 7'h5D; 7'h2C: c = 7'h5A; 7'h2D: c = 7'h58;
			7'h2E: c = 7'h43; 7'h2F: c = 7'h56;
			7'h30: c = 7'h42; 7'h31: c = 7'h4E; 7'h32: c = 7'h4D; 7'h33: c = 7'h2C;
			7'h34: c = 7'h2E; 7'h35: c = 7'h2F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
			7'h47: c = 7'h37; 7'h48: c = 7'h38; 7'h49: c = 7'h39; 7'h4A: c = 7'h2D;
			7'h4B: c = 7'h34; 7'h4C: c = 7'h35; 7'h4D: c = 7'h36; 7'h4E: c = 7'h2B;
			7'h4F: c = 7'h31;
			7'h50: c = 7'h32; 7'h51: c = 7'h33; 7'h52: c = 7'h30; 7'h53: c = 7'h2E;
			7'h73: c = 7'h5C; 7'h7D: c = 7'h5C;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	// Shifted map: differs from the plain map only on symbol keys
	function automatic logic [6:0] shifted_map(input logic [6:0] code);
		logic [6:0] c;
		c = plain_map(code);
		case (code)
			7'h02: c = 7'h21; 7'h03: c = 7'h22; 7'h04: c = 7'h23; 7'h05: c = 7'h24;
			7'h06: c = 7'h25; 7'h07: c = 7'h26; 7'h08: c = 7'h27; 7'h09: c = 7'h28;
			7'h0A: c = 7'h29; 7'h0B: c = 7'h7E; 7'h0C: c = 7'h3D; 7'h0D: c = 7'h7E;
			7'h1A: c = 7'h60; 7'h1B: c = 7'h7B; 7'h27: c = 7'h2B; 7'h28: c = 7'h2A;
			7'h2B: c = 7'h7D; 7'h33: c = 7'h3C; 7'h34: c = 7'h3E; 7'h35: c = 7'h3F;
			7'h73: c = 7'h5F; 7'h7D: c = 7'h7C;
			default: c = plain_map(code);
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: src/ksd_char_map.sv
// ----------------------------------------------------------------------------
// ksd_char_map
// Maps a make code to ASCII and applies letter case from caps lock and shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_char_map
	import ksd_pkg::*;
(
	input  wire logic [7:0] scan_byte,
	input  wire logic       is_byte,
	input  wire logic       shift_any,
	input  wire logic       caps,
	output logic            char_valid,
	output logic [6:0]      char_code
);

	logic [6:0] raw;
	logic       letter;

	// Table lookup, make codes only
	always_comb begin
		raw = shift_any ? shifted_map(scan_byte[6:0]) : plain_map(scan_byte[6:0]);
		if (!is_byte || scan_byte[7]) begin
			raw = 7'h00;
		end
	end

	// Lower case unless exactly one of caps and shift
	assign letter = (raw >= 7'h41) && (raw <= 7'h5A);

	always_comb begin
		char_code = raw;
		if (letter && (caps == shift_any)) begin
			char_code = raw + 7'h20;
		end
	end

	assign char_valid = (raw != 7'h00);

endmodule

`default_nettype wire

// File: src/ksd_cmd_queue.sv
// ----------------------------------------------------------------------------
// ksd_cmd_queue
// Byte queue toward the keyboard: pushes the LED command pair, pops one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_cmd_queue
	import ksd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ksd_qctl_t  ctl,
	input  wire logic [2:0] led_bits,
	output logic            avail,
	output logic [7:0]      head_byte
);

	logic [7:0]        mem [CMD_QUEUE_DEPTH];
	logic [QIDX_W-1:0] head_q;
	logic [QIDX_W-1:0] tail_q;
	logic [QCNT_W-1:0] count_q;
	logic              acc0;
	logic              acc1;
	logic [QIDX_W-1:0] tail_p1;
	logic [QIDX_W-1:0] tail_p2;
	logic [QIDX_W-1:0] head_p1;
	logic [7:0]        led_byte;

	function automatic logic [QIDX_W-1:0] wrap_inc(input logic [QIDX_W-1:0] i);
		return (i == QIDX_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : i + QIDX_W'(1);
	endfunction

	assign led_byte = {5'b0, led_bits};

	// Drop what does not fit
	assign acc0 = ctl.push && (count_q < QCNT_W'(CMD_QUEUE_DEPTH));
	assign acc1 = ctl.push && (count_q < QCNT_W'(CMD_QUEUE_DEPTH - 1));

	assign tail_p1 = wrap_inc(tail_q);
	assign tail_p2 = wrap_inc(tail_p1);
	assign head_p1 = wrap_inc(head_q);

	// Head byte; an empty queue shows the LED command that a push would store
	assign avail     = (count_q != '0);
	assign head_byte = (count_q != '0) ? mem[head_q] : LED_CMD;

	// Storage
	always_ff @(posedge clk) begin
		if (acc0) begin
			mem[tail_q] <= LED_CMD;
		end
		if (acc1) begin
			mem[tail_p1] <= led_byte;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (acc1) begin
				tail_q <= tail_p2;
			end else if (acc0) begin
				tail_q <= tail_p1;
			end
			if (ctl.pop) begin
				head_q <= head_p1;
			end
			count_q <= count_q + QCNT_W'(acc0) + QCNT_W'(acc1) - QCNT_W'(ctl.pop);
		end
	end

endmodule

`default_nettype wire

// File: src/keyboard_scancode_decoder.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder
// Scan code set 1 decoder with shift tracking, lock LEDs and command queue.
// ----------------------------------------------------------------------------
// Each request is one keyboard byte or a start request and yields exactly one
// result: a character, a key event, a byte to send to the keyboard and the
// current LED bits. Requests are registered on entry, decoded against the
// shift, LED, acknowledge and queue state, and the result is registered on
// exit, so one request is taken per clock while the result is not stalled;
// a stalled result holds the pipeline. The 32-entry command queue
// is a register file with one read port at the head.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_scancode_decoder
	import ksd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_data,
	// requests
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       action,
	input  wire logic [7:0] scan_byte,
	// results
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            char_valid,
	output logic [6:0]      char_code,
	output logic [2:0]      key_event,
	output logic            send_valid,
	output logic [7:0]      send_byte,
	output logic [2:0]      led_state
);

	logic       init_leds_q;
	logic [2:0] init_leds_val_q;
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] byte_s1;
	logic [1:0] shift_q;
	logic [2:0] leds_q;
	logic       await_q;
	logic [7:0] pend_q;
	logic       advance;
	logic       is_byte;
	logic       ch_valid;
	logic [6:0] ch_code;
	key_event_t ev;
	logic [1:0] shift_n;
	logic [2:0] leds_n;
	logic       await_n;
	logic [7:0] pend_n;
	logic       resend;
	logic       sv;
	logic [7:0] sb;
	logic       q_push;
	logic       q_pop;
	ksd_qctl_t  qctl;
	logic       q_avail;
	logic [7:0] q_head;

	assign cfg_ready = 1'b1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_leds_q     <= 1'b0;
			init_leds_val_q <= '0;
		end else if (cfg_valid) begin
			init_leds_q     <= 1'b1;
			init_leds_val_q <= cfg_data;
		end
	end

	// Pipeline control
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			action_s1 <= action;
			byte_s1   <= scan_byte;
		end
	end

	assign is_byte = (action_s1 == ACT_BYTE);

	ksd_char_map u_map (
		.scan_byte  (byte_s1),
		.is_byte    (is_byte),
		.shift_any  (shift_q != 2'b00),
		.caps       (leds_q[LED_CAPS]),
		.char_valid (ch_valid),
		.char_code  (ch_code)
	);

	// Byte decode and state update
	always_comb begin
		shift_n = shift_q;
		leds_n  = leds_q;
		await_n = await_q;
		ev      = EV_NONE;
		resend  = 1'b0;
		q_push  = 1'b0;
		if (action_s1 == ACT_START) begin
			leds_n = init_leds_q ? init_leds_val_q : 3'b000;
			q_push = 1'b1;
		end else begin
			case (byte_s1)
				SC_TAB:      ev = EV_TAB;
				SC_F11:      ev = EV_F11;
				SC_LSH_MAKE: shift_n = shift_q | 2'b01;
				SC_RSH_MAKE: shift_n = shift_q | 2'b10;
				SC_LSH_BRK:  shift_n = shift_q & 2'b10;
				SC_RSH_BRK:  shift_n = shift_q & 2'b01;
				SC_CAPS: begin
					leds_n[LED_CAPS] = ~leds_q[LED_CAPS];
					q_push           = 1'b1;
				end
				SC_NUM: begin
					leds_n[LED_NUM] = ~leds_q[LED_NUM];
					q_push          = 1'b1;
				end
				SC_SCROLL: begin
					leds_n[LED_SCROLL] = ~leds_q[LED_SCROLL];
					q_push             = 1'b1;
				end
				SC_F1:     if (shift_q != 2'b00) ev = EV_SH_F1;
				SC_F2:     if (shift_q != 2'b00) ev = EV_SH_F2;
				KB_ACK:    await_n = 1'b0;
				KB_RESEND: resend = await_q;
				default:   ev = EV_NONE;
			endcase
		end
	end

	// Send path: resend, else next queued byte when nothing awaits an ack;
	// a push into an empty queue makes its LED command the head at once
	always_comb begin
		q_pop  = 1'b0;
		pend_n = pend_q;
		sv     = 1'b0;
		sb     = 8'h00;
		if (resend) begin
			sv = 1'b1;
			sb = pend_q;
		end else if ((q_avail || q_push) && !await_n) begin
			q_pop  = 1'b1;
			pend_n = q_head;
			sv     = 1'b1;
			sb     = q_head;
		end
	end

	assign qctl = '{push: advance && q_push, pop: advance && q_pop};

	ksd_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (qctl),
		.led_bits  (leds_n),
		.avail     (q_avail),
		.head_byte (q_head)
	);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			leds_q  <= '0;
			await_q <= 1'b0;
			pend_q  <= '0;
		end else if (advance) begin
			shift_q <= shift_n;
			leds_q  <= leds_n;
			await_q <= await_n || q_pop;
			pend_q  <= pend_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			char_valid <= ch_valid;
			char_code  <= ch_code;
			key_event  <= ev;
			send_valid <= sv;
			send_byte  <= sb;
			led_state  <= leds_n;
		end
	end

endmodule

`default_nettype wire

// File: dv/ksd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_checker
// Watches the request, result and configuration channels of the scan code
// decoder. It keeps its own model of the shift, LED, acknowledge and command
// queue state, works out the result of each accepted request and compares
// every accepted result, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_checker
	import ksd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic [2:0] cfg_data,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic       action,
	input  wire logic [7:0] scan_byte,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic       char_valid,
	input  wire logic [6:0] char_code,
	input  wire logic [2:0] key_event,
	input  wire logic       send_valid,
	input  wire logic [7:0] send_byte,
	input  wire logic [2:0] led_state,
	output int              errors,
	output int              pending
);

	typedef struct packed {
		logic       chr_vld;
		logic [6:0] chr;
		key_event_t evt;
		logic       snd_vld;
		logic [7:0] snd;
		logic [2:0] leds;
	} key_result_t;

	// Shadow of the decoder state
	logic [2:0]  start_leds;
	logic [1:0]  shift_keys;
	logic [2:0]  lock_bits;
	logic        ack_wait;
	logic [7:0]  last_sent;
	logic [7:0]  kbd_cmds [$];
	key_result_t results_due [$];
	int          err_cnt;

	// Scan code to ASCII, before case adjustment
	function automatic logic [7:0] key_char(input logic [6:0] code, input logic shifted);
		logic [7:0] c;
		c = 8'h00;
		case (code)
			7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07, 7'h08, 7'h09, 7'h0A:
				c = 8'h31 + {1'b0, code} - 8'h02;
			7'h0B: c = "0";
			7'h0C: c = "-";
			7'h0D: c = "^";
			7'h0E: c = 8'h08;
			7'h10: c = "Q"; 7'h11: c = "W"; 7'h12: c = "E"; 7'h13: c = "R";
			7'h14: c = "T"; 7'h15: c = "Y"; 7'h16: c = "U"; 7'h17: c = "I";
			7'h18: c = "O"; 7'h19: c = "P"; 7'h1A: c = "@"; 7'h1B: c = "[";
			7'h1C: c = 8'h0A; 7'h1E: c = "A"; 7'h1F: c = "S";
			7'h20: c = "D"; 7'h21: c = "F"; 7'h22: c = "G"; 7'h23: c = "H";
			7'h24: c = "J"; 7'h25: c = "K"; 7'h26: c = "L"; 7'h27: c = ";";
			7'h28: c = ":"; 7'h2B: c = "]"; 7'h2C: c = "Z"; 7'h2D: c = "X";
			7'h2E: c = "C"; 7'h2F: c = "V";
			7'h30: c = "B"; 7'h31: c = "N"; 7'h32: c = "M"; 7'h33: c = ",";
			7'h34: c = "."; 7'h35: c = "/"; 7'h37: c = "*"; 7'h39: c = " ";
			7'h47: c = "7"; 7'h48: c = "8"; 7'h49: c = "9"; 7'h4A: c = "-";
			7'h4B: c = "4"; 7'h4C: c = "5"; 7'h4D: c = "6"; 7'h4E: c = "+";
			7'h4F: c = "1"; 7'h50: c = "2"; 7'h51: c = "3"; 7'h52: c = "0";
			7'h53: c = ".";
			7'h73, 7'h7D: c = 8'h5C;
			default: c = 8'h00;
		endcase
		// symbol keys change under shift, letters and keypad do not
		if (shifted) begin
			case (code)
				7'h02: c = "!"; 7'h03: c = 8'h22; 7'h04: c = "#"; 7'h05: c = "$";
				7'h06: c = "%"; 7'h07: c = "&"; 7'h08: c = 8'h27; 7'h09: c = "(";
				7'h0A: c = ")"; 7'h0B: c = "~"; 7'h0C: c = "="; 7'h0D: c = "~";
				7'h1A: c = 8'h60; 7'h1B: c = "{"; 7'h27: c = "+"; 7'h28: c = "*";
				7'h2B: c = "}"; 7'h33: c = "<"; 7'h34: c = ">"; 7'h35: c = "?";
				7'h73: c = "_"; 7'h7D: c = "|";
				default: ;
			endcase
		end
		return c;
	endfunction

	// Queue a keyboard byte; a full queue drops it
	task automatic push_cmd(input logic [7:0] v);
		if (kbd_cmds.size() < CMD_QUEUE_DEPTH)
			kbd_cmds.push_back(v);
	endtask

	task automatic queue_led_update();
		push_cmd(LED_CMD);
		push_cmd({5'b0, lock_bits});
	endtask

	// Next-state and result of one request
	task automatic decode_request(input logic act, input logic [7:0] b,
	                              output key_result_t r);
		logic [7:0] ch;
		key_event_t ev;
		logic       sent;
		logic [7:0] sb;
		logic       shifted;
		ch = 8'h00;
		ev = EV_NONE;
		sent = 1'b0;
		sb = 8'h00;
		shifted = (shift_keys != 2'b00);
		if (act == ACT_START) begin
			lock_bits = start_leds;
			queue_led_update();
		end else begin
			if (!b[7]) begin
				ch = key_char(b[6:0], shifted);
				// lower case unless exactly one of caps lock and shift is on
				if (ch >= "A" && ch <= "Z" && lock_bits[LED_CAPS] == shifted)
					ch = ch + 8'h20;
			end
			case (b)
				SC_TAB:      ev = EV_TAB;
				SC_F11:      ev = EV_F11;
				SC_LSH_MAKE: shift_keys[0] = 1'b1;
				SC_RSH_MAKE: shift_keys[1] = 1'b1;
				SC_LSH_BRK:  shift_keys[0] = 1'b0;
				SC_RSH_BRK:  shift_keys[1] = 1'b0;
				SC_CAPS: begin
					lock_bits[LED_CAPS] = ~lock_bits[LED_CAPS];
					queue_led_update();
				end
				SC_NUM: begin
					lock_bits[LED_NUM] = ~lock_bits[LED_NUM];
					queue_led_update();
				end
				SC_SCROLL: begin
					lock_bits[LED_SCROLL] = ~lock_bits[LED_SCROLL];
					queue_led_update();
				end
				SC_F1: if (shifted) ev = EV_SH_F1;
				SC_F2: if (shifted) ev = EV_SH_F2;
				KB_ACK: ack_wait = 1'b0;
				KB_RESEND: begin
					if (ack_wait) begin
						sent = 1'b1;
						sb = last_sent;
					end
				end
				default: ;
			endcase
		end
		// send the head byte when the line is free
		if (!sent && kbd_cmds.size() > 0 && !ack_wait) begin
			last_sent = kbd_cmds.pop_front();
			ack_wait = 1'b1;
			sent = 1'b1;
			sb = last_sent;
		end
		r.chr_vld = (ch != 8'h00);
		r.chr = ch[6:0];
		r.evt = ev;
		r.snd_vld = sent;
		r.snd = sb;
		r.leds = lock_bits;
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
			         exp_v, act_v);
			err_cnt++;
		end
	endtask

	// Compare results first, then model the request taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		key_result_t due;
		key_result_t fresh;
		if (!arst_n) begin
			start_leds = 3'd0;
			shift_keys = 2'd0;
			lock_bits = 3'd0;
			ack_wait = 1'b0;
			last_sent = 8'h00;
			kbd_cmds.delete();
			results_due.delete();
			err_cnt = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$display("%0t: result with none due, expected nothing, actual %0h_%0h_%0h_%0h_%0h_%0h",
					         $time, char_valid, char_code, key_event, send_valid,
					         send_byte, led_state);
					err_cnt++;
				end else begin
					due = results_due.pop_front();
					check_field("char_valid", due.chr_vld, char_valid);
					check_field("char_code", due.chr, char_code);
					check_field("key_event", due.evt, key_event);
					check_field("send_valid", due.snd_vld, send_valid);
					check_field("send_byte", due.snd, send_byte);
					check_field("led_state", due.leds, led_state);
				end
			end
			if (in_valid && !in_stall) begin
				decode_request(action, scan_byte, fresh);
				results_due.push_back(fresh);
			end
			if (cfg_valid && cfg_ready)
				start_leds = cfg_data;
		end
		errors = err_cnt;
		pending = results_due.size();
	end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the scan code decoder with a directed run over the special keys,
// the acknowledge and resend replies and the extreme codes, then with
// phases of weighted random keyboard traffic under several LED settings,
// with random gaps, random result stalls and one long stall that backs up
// the pipeline. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import ksd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 225;
	localparam int NUM_PHASES  = 6;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic       action;
	logic [7:0] scan_byte;
	logic       out_valid;
	logic       out_stall;
	logic       char_valid;
	logic [6:0] char_code;
	logic [2:0] key_event;
	logic       send_valid;
	logic [7:0] send_byte;
	logic [2:0] led_state;
	int         errors;
	int         pending;
	int         cycles;
	logic       no_gaps;
	logic       squeeze_req;

	logic [7:0] directed_codes [24] = '{
		KB_RESEND, KB_ACK, KB_ACK, KB_RESEND, 8'h00, 8'h7F, 8'h80, 8'hFF,
		8'h1E, SC_LSH_MAKE, 8'h1E, 8'h02, SC_F1, SC_F2, SC_LSH_BRK, SC_RSH_MAKE,
		8'h0D, SC_RSH_BRK, SC_TAB, SC_F11, SC_F1, SC_CAPS, SC_NUM, SC_SCROLL
	};

	keyboard_scancode_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.scan_byte  (scan_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_valid (char_valid),
		.char_code  (char_code),
		.key_event  (key_event),
		.send_valid (send_valid),
		.send_byte  (send_byte),
		.led_state  (led_state)
	);

	ksd_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.scan_byte  (scan_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_valid (char_valid),
		.char_code  (char_code),
		.key_event  (key_event),
		.send_valid (send_valid),
		.send_byte  (send_byte),
		.led_state  (led_state),
		.errors     (errors),
		.pending    (pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL keyboard_scancode_decoder");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		int  hold_left;
		logic squeeze_taken;
		hold_left = 0;
		squeeze_taken = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze_req && !squeeze_taken) begin
				squeeze_taken = 1'b1;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else begin
				out_stall = !no_gaps && ($urandom_range(99) < 9);
			end
		end
	end

	// Offer one request and hold it until taken
	task automatic send_item(input logic act, input logic [7:0] b);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 9) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		scan_byte = b;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
	endtask

	// Write the start LED register; only called with the block idle
	task automatic write_start_leds(input logic [2:0] v);
		@(negedge clk);
		in_valid = 1'b0;
		cfg_valid = 1'b1;
		cfg_data = v;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
	endtask

	// Weighted random keyboard traffic; ack_pct sets how fast the queue drains
	task automatic send_random(input int ack_pct);
		int r;
		logic [7:0] b;
		r = $urandom_range(99);
		b = 8'($urandom_range(255));
		if (r < ack_pct) begin
			send_item(ACT_BYTE, KB_ACK);
		end else if (r < ack_pct + 5) begin
			send_item(ACT_BYTE, KB_RESEND);
		end else if (r < ack_pct + 15) begin
			case ($urandom_range(2))
				0: send_item(ACT_BYTE, SC_CAPS);
				1: send_item(ACT_BYTE, SC_NUM);
				default: send_item(ACT_BYTE, SC_SCROLL);
			endcase
		end else if (r < ack_pct + 21) begin
			case ($urandom_range(3))
				0: send_item(ACT_BYTE, SC_LSH_MAKE);
				1: send_item(ACT_BYTE, SC_RSH_MAKE);
				2: send_item(ACT_BYTE, SC_LSH_BRK);
				default: send_item(ACT_BYTE, SC_RSH_BRK);
			endcase
		end else if (r < ack_pct + 24) begin
			send_item(ACT_START, b);
		end else if (r < ack_pct + 28) begin
			case ($urandom_range(3))
				0: send_item(ACT_BYTE, SC_TAB);
				1: send_item(ACT_BYTE, SC_F11);
				2: send_item(ACT_BYTE, SC_F1);
				default: send_item(ACT_BYTE, SC_F2);
			endcase
		end else if (r < ack_pct + 40) begin
			send_item(ACT_BYTE, b);
		end else if (r < ack_pct + 50) begin
			send_item(ACT_BYTE, {1'b1, b[6:0]});
		end else begin
			send_item(ACT_BYTE, {1'b0, b[6:0]});
		end
	endtask

	// Stimulus and verdict
	initial begin
		int ack_pct [NUM_PHASES] = '{30, 4, 40, 8, 20, 12};
		logic [2:0] phase_leds;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 3'd0;
		in_valid = 1'b0;
		action = ACT_BYTE;
		scan_byte = 8'h00;
		no_gaps = 1'b0;
		squeeze_req = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: all LEDs on, then replies, extremes and special keys
		write_start_leds(3'd7);
		send_item(ACT_START, 8'hFF);
		foreach (directed_codes[i])
			send_item(ACT_BYTE, directed_codes[i]);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: phase_leds = 3'd0;
				1: phase_leds = 3'd7;
				2: phase_leds = 3'd5;
				3: phase_leds = 3'd2;
				default: phase_leds = 3'($urandom_range(7));
			endcase
			write_start_leds(phase_leds);
			send_item(ACT_START, 8'h00);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				no_gaps = (p == 2 && n < 150);
				if (p == 3 && n == 50)
					squeeze_req = 1'b1;
				send_random(ack_pct[p]);
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASS keyboard_scancode_decoder");
		else
			$display("FAIL keyboard_scancode_decoder");
		$finish;
	end

endmodule

`default_nettype wire
